### rtl/bounded_lcg_xorshift_random_assert.svh
// Assertion macros shared by the RTL.
// BLXR_ASSERT checks on clk and is held off while rst_n is low.
// BLXR_ASSERT_ALWAYS checks on clk at every edge, reset included.
`ifndef BOUNDED_LCG_XORSHIFT_RANDOM_ASSERT_SVH
`define BOUNDED_LCG_XORSHIFT_RANDOM_ASSERT_SVH

`ifndef ASSERT_OFF
`define BLXR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BLXR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BLXR_ASSERT(lbl, prop, msg)
`define BLXR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/blxr_pkg.sv
package blxr_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned CODE_W = 3;

  // generator constants
  localparam logic [17:0]       MULT_K = 18'd198277;
  localparam logic [1:0]        ADD_K  = 2'd3;
  localparam logic [DATA_W-1:0] SEED_K = 64'd9316722631499553187;
  localparam int unsigned       SHL_K  = 3;
  localparam int unsigned       SHR_K  = 7;

  // rejection sampling gives up after this many draws
  localparam int unsigned MAX_DRAWS = 64;
  localparam int unsigned DRAW_CNT_W = $clog2(MAX_DRAWS + 1);

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [CODE_W-1:0] {
    WIDTH_1  = 3'd0,
    WIDTH_8  = 3'd1,
    WIDTH_16 = 3'd2,
    WIDTH_32 = 3'd3,
    WIDTH_64 = 3'd4
  } blxr_width_t;

  // classified request as it sits in the queue
  typedef struct packed {
    logic              bounded;  // rejection sampling applies
    logic [DATA_W-1:0] mask;     // width mask, or cover mask of the bound
    logic [DATA_W-1:0] bound;    // bound truncated to the width
  } blxr_item_t;

endpackage

### rtl/blxr_front.sv
module blxr_front (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [blxr_pkg::CODE_W-1:0]         in_width_code,
  input  logic [blxr_pkg::DATA_W-1:0]         in_bound,
  input  logic                                q_ready,
  output logic                                q_push,
  output blxr_pkg::blxr_item_t                q_item
);
  import blxr_pkg::*;

  logic [DATA_W-1:0] wmask;
  logic [DATA_W-1:0] bnd;
  logic [DATA_W-1:0] cover_m;
  logic              one_bit;

  always_comb begin
    one_bit = 1'b0;
    unique case (blxr_width_t'(in_width_code))
      WIDTH_1: begin
        wmask   = DATA_W'(1);
        one_bit = 1'b1;
      end
      WIDTH_8:  wmask = DATA_W'(8'hFF);
      WIDTH_16: wmask = DATA_W'(16'hFFFF);
      WIDTH_32: wmask = DATA_W'(32'hFFFF_FFFF);
      WIDTH_64: wmask = '1;
      default:  wmask = '1;  // unused codes act as 64 bits
    endcase
  end

  // smear the top set bit of the bound downward
  always_comb begin
    bnd     = in_bound & wmask;
    cover_m = bnd;
    cover_m = cover_m | (cover_m >> 1);
    cover_m = cover_m | (cover_m >> 2);
    cover_m = cover_m | (cover_m >> 4);
    cover_m = cover_m | (cover_m >> 8);
    cover_m = cover_m | (cover_m >> 16);
    cover_m = cover_m | (cover_m >> 32);
  end

  always_comb begin
    q_item.bound   = bnd;
    q_item.bounded = !one_bit && (bnd != '0);
    q_item.mask    = q_item.bounded ? cover_m : wmask;
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

endmodule

### rtl/blxr_queue.sv
module blxr_queue #(
  parameter int unsigned DEPTH = blxr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 push_ready,
  input  blxr_pkg::blxr_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop,
  output blxr_pkg::blxr_item_t pop_item
);
  import blxr_pkg::*;
  `include "bounded_lcg_xorshift_random_assert.svh"

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  blxr_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `BLXR_ASSERT(a_q_no_overflow, push |-> push_ready, "queue push while full")
  `BLXR_ASSERT(a_q_no_underflow, pop |-> pop_valid, "queue pop while empty")
  `BLXR_ASSERT(a_q_fill, (push && !pop) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)),
               "queue fill count did not advance on push")

endmodule

### rtl/blxr_back.sv
module blxr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  blxr_pkg::blxr_item_t        q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [blxr_pkg::DATA_W-1:0] out_value
);
  import blxr_pkg::*;
  `include "bounded_lcg_xorshift_random_assert.svh"

  localparam int unsigned PLO_W = 32 + 18 + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ADD, ST_CHK} st_t;

  st_t               st_r, st_nxt;
  logic [DATA_W-1:0] gen_r, gen_nxt;
  logic [PLO_W-1:0]  plo_r, plo_nxt;
  logic [31:0]       phi_r, phi_nxt;
  blxr_item_t        item_r, item_nxt;
  logic [DATA_W-1:0] draw_r, draw_nxt;
  logic [DRAW_CNT_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;

  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] mix1;
  logic [DATA_W-1:0] mix2;
  logic              below;
  logic              done;
  logic              out_free;
  logic              load_out;
  logic [DATA_W-1:0] result;

  // multiply split in two 32-bit halves; high half only needs its low word
  assign plo_nxt = PLO_W'(gen_r[31:0]) * PLO_W'(MULT_K) + PLO_W'(ADD_K);
  assign phi_nxt = gen_r[63:32] * 32'(MULT_K);

  assign sum  = DATA_W'(plo_r) + {phi_r, 32'b0};
  assign mix1 = sum ^ (sum << SHL_K);
  assign mix2 = mix1 ^ (mix1 >> SHR_K);

  assign below    = draw_r < item_r.bound;
  assign done     = !item_r.bounded || below || (cnt_r == DRAW_CNT_W'(MAX_DRAWS));
  assign result   = (!item_r.bounded || below) ? draw_r : (draw_r & (item_r.mask >> 1));
  assign out_free = !out_valid_r || out_ready;
  assign load_out = (st_r == ST_CHK) && done && out_free;

  always_comb begin
    st_nxt        = st_r;
    gen_nxt       = gen_r;
    item_nxt      = item_r;
    draw_nxt      = draw_r;
    cnt_nxt       = cnt_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          item_nxt = q_item;
          q_pop    = 1'b1;
          cnt_nxt  = '0;
          st_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        st_nxt = ST_ADD;
      end
      ST_ADD: begin
        gen_nxt  = mix2;
        draw_nxt = mix2 & item_r.mask;
        cnt_nxt  = cnt_r + DRAW_CNT_W'(1);
        st_nxt   = ST_CHK;
      end
      ST_CHK: begin
        // products for the next draw are taken here from the updated state
        if (!done) begin
          st_nxt = ST_ADD;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = result;
          if (q_valid) begin
            item_nxt = q_item;
            q_pop    = 1'b1;
            cnt_nxt  = '0;
            st_nxt   = ST_ADD;
          end else begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      gen_r       <= SEED_K;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      gen_r       <= gen_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      plo_r       <= plo_nxt;
      phi_r       <= phi_nxt;
      item_r      <= item_nxt;
      draw_r      <= draw_nxt;
      out_value_r <= out_value_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  `BLXR_ASSERT(a_bounded_result, (load_out && item_r.bounded) |-> (result < item_r.bound),
               "bounded result not below bound")
  `BLXR_ASSERT(a_gen_hold, (st_r != ST_ADD) |=> $stable(gen_r),
               "generator state moved outside a draw")
  `BLXR_ASSERT(a_cnt_range, cnt_r <= DRAW_CNT_W'(MAX_DRAWS),
               "draw count past limit")

endmodule

### rtl/bounded_lcg_xorshift_random.sv
// Bounded random number source: 64-bit LCG (x198277 + 3) whitened by
// xor-shift left 3 then right 7, with rejection sampling against a bound.
// Request channel (in_valid/in_ready): in_width_code picks 1, 8, 16, 32 or
// 64 bits (unused codes act as 64), in_bound is an exclusive limit, 0 for a
// raw draw (1-bit requests ignore it). Result channel (out_valid/out_ready):
// out_value, zero-extended. Each request gives exactly one result
// transaction, in request order. A generator step is split in two (the
// multiply into registers, then add and xor-shifts); the bound compare of a
// draw overlaps the multiply of the next. From an idle block a request
// passes the queue, the IDLE, MUL, ADD and CHK states and the output
// register; each draw runs through ADD and CHK, at most 64 draws per
// request, and the next request is taken in CHK of the last draw.
// Requests are classified on entry and wait in a small queue, so the
// request side keeps flowing while a draw loop runs or a result waits.
// If out_ready stays low the finished result holds in the output register,
// the back end waits with its next result, and the queue then fills and
// drops in_ready. Synchronous reset (rst_n low) loads the seed,
// empties the queue and clears out_valid.
module bounded_lcg_xorshift_random #(
  parameter int unsigned QUEUE_DEPTH = blxr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [blxr_pkg::CODE_W-1:0] in_width_code,
  input  logic [blxr_pkg::DATA_W-1:0] in_bound,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [blxr_pkg::DATA_W-1:0] out_value
);
  import blxr_pkg::*;

  blxr_item_t push_item;
  blxr_item_t pop_item;
  logic       push;
  logic       push_ready;
  logic       pop_valid;
  logic       pop;

  // classify width and bound, derive the cover mask
  blxr_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_width_code (in_width_code),
    .in_bound      (in_bound),
    .q_ready       (push_ready),
    .q_push        (push),
    .q_item        (push_item)
  );

  // decouples request intake from the draw loop
  blxr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  // generator, rejection loop and output register
  blxr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_item    (pop_item),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value)
  );

endmodule
